FILE: hdl/pdsl_pkg.sv
// Shared constants for the filtered-derivative PID controller.
`timescale 1ns / 1ps
package pdsl_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_BOUND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_LIMIT = 3'd6;

   // 0.98 in Q0.16
   localparam logic [15:0] ALPHA_MAX = 16'd64225;
   // saturation of the raw derivative, 2^47 - 1
   localparam logic [47:0] DERIV_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [14:0] CORR_LIMIT_RST = 15'd32767;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

endpackage

FILE: hdl/pid_filtered_derivative_slew_limit.sv
// PID controller with filtered derivative, anti-windup, clamp and slew limit.
`timescale 1ns / 1ps
// Usage:
//  - Request channel (req_valid / req_stall) carries one word: req_type,
//    req_error_in (signed Q.F error) and req_step_time (unsigned Q8.24 dt).
//    req_type 1 clears the controller state and answers 0.
//  - Response channel (rsp_valid / rsp_stall) returns one word per request:
//    rsp_correction, the clamped, slew-limited integer correction.
//  - Config is a plain write port (csr_wr_en, csr_index, csr_wdata), written
//    only while the block is idle, a rule for the user that no logic enforces.
//  - Sequence: an update runs from accept to response through a
//    57-step restoring divider for (de << 24) / dt, then 19 sequencer steps
//    through one shared 33x33 multiplier whose product is registered, then
//    one hand-off step into the output register.
//    A clear request or a zero dt goes straight from accept to the hand-off step.
//  - Throughput: one word at a time; req_stall is high while a word is in
//    work. The response sits in its own output register, so the next word
//    is taken while an earlier response still waits on rsp_stall.
//  - When the receiver stalls, the finished result waits in the sequencer's
//    last step until the output register frees up.
//  - Reset (synchronous, active high) loads register defaults
//    (correction_limit 32767, rest 0) and clears the controller state.
module pid_filtered_derivative_slew_limit #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic signed [31:0] req_error_in,
   input  logic [31:0] req_step_time,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_correction,
   input  logic csr_wr_en,
   input  logic [pdsl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdsl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pdsl_pkg::*;

   localparam int TF = 2 * FRAC_BITS;
   localparam int ACC_W = 84;
   localparam int NUM_W = 57;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DIV = 5'd1;
   localparam logic [4:0] S_RAW = 5'd2;
   localparam logic [4:0] S_FAH = 5'd3;
   localparam logic [4:0] S_FAHA = 5'd4;
   localparam logic [4:0] S_FAL = 5'd5;
   localparam logic [4:0] S_FALA = 5'd6;
   localparam logic [4:0] S_FAD = 5'd7;
   localparam logic [4:0] S_IM = 5'd8;
   localparam logic [4:0] S_IA = 5'd9;
   localparam logic [4:0] S_PM = 5'd10;
   localparam logic [4:0] S_PA = 5'd11;
   localparam logic [4:0] S_GM = 5'd12;
   localparam logic [4:0] S_GA = 5'd13;
   localparam logic [4:0] S_DHM = 5'd14;
   localparam logic [4:0] S_DHA = 5'd15;
   localparam logic [4:0] S_DLM = 5'd16;
   localparam logic [4:0] S_DLA = 5'd17;
   localparam logic [4:0] S_TR = 5'd18;
   localparam logic [4:0] S_CL = 5'd19;
   localparam logic [4:0] S_SL = 5'd20;
   localparam logic [4:0] S_DONE = 5'd21;

   // config registers
   logic signed [31:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [15:0] alpha_ff;
   logic [30:0] bound_ff;
   logic [14:0] lim_ff, slew_ff;

   // controller state
   logic signed [31:0] integ_ff, integ_in, prev_int_ff, prev_int_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [47:0] sm_ff, sm_in;
   logic signed [15:0] last_out_ff, last_out_in;
   logic seeded_ff, seeded_in;

   // sequencer and datapath
   logic [4:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic signed [31:0] err_ff, err_in;
   logic [31:0] dt_ff, dt_in;
   logic neg_ff, neg_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic signed [47:0] raw_ff, raw_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff;
   logic signed [32:0] op_a, op_b;
   logic signed [15:0] v_ff, v_in;
   logic signed [15:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_corr_ff, rsp_corr_in;

   // combinational helpers
   logic accept;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [33:0] trial;
   logic [32:0] shifted;
   logic [47:0] qmag;
   logic signed [48:0] dflt;
   logic signed [ACC_W-1:0] prod_ext, raw_ext, rnd;
   logic signed [41:0] inc, isum, bnd_ext;
   logic signed [ACC_W-1:0] lim_ext;
   logic signed [17:0] delta, v2, sl_ext, lim18;
   logic [15:0] alpha_use;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_correction = rsp_corr_ff;
   assign alpha_use = (alpha_ff > ALPHA_MAX) ? ALPHA_MAX : alpha_ff;

   // shared multiplier operand select
   assign dflt = {sm_ff[47], sm_ff} - {raw_ff[47], raw_ff};
   always_comb begin
      case (state_ff)
         S_FAH: begin
            op_a = {17'd0, alpha_use};
            op_b = {{8{dflt[48]}}, dflt[48:24]};
         end
         S_FAL: begin
            op_a = {17'd0, alpha_use};
            op_b = {9'd0, dflt[23:0]};
         end
         S_IM: begin
            op_a = {err_ff[31], err_ff};
            op_b = {1'b0, dt_ff};
         end
         S_PM: begin
            op_a = {gain_p_ff[31], gain_p_ff};
            op_b = {err_ff[31], err_ff};
         end
         S_GM: begin
            op_a = {gain_i_ff[31], gain_i_ff};
            op_b = {integ_ff[31], integ_ff};
         end
         S_DHM: begin
            op_a = {gain_d_ff[31], gain_d_ff};
            op_b = {{9{sm_ff[47]}}, sm_ff[47:24]};
         end
         S_DLM: begin
            op_a = {gain_d_ff[31], gain_d_ff};
            op_b = {9'd0, sm_ff[23:0]};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_ext = {{(ACC_W-66){prod_ff[65]}}, prod_ff};
   assign raw_ext = {{(ACC_W-48){raw_ff[47]}}, raw_ff};
   assign diff = {req_error_in[31], req_error_in} - {last_err_ff[31], last_err_ff};
   assign mag = diff[32] ? (33'd0 - diff) : diff;
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial = {1'b0, shifted} - {2'b00, dt_ff};
   assign qmag = (|quo_ff[NUM_W-1:47]) ? DERIV_MAX : {1'b0, quo_ff[46:0]};
   assign inc = 42'((prod_ff + (prod_ff[65] ? 66'sh0FF_FFFF : 66'sh0)) >>> 24);
   assign isum = {{10{integ_ff[31]}}, integ_ff} + inc;
   assign bnd_ext = {11'd0, bound_ff};
   assign rnd = acc_ff + (acc_ff[ACC_W-1]
      ? {{(ACC_W-TF){1'b0}}, {TF{1'b1}}} : {ACC_W{1'b0}});
   assign lim_ext = {{(ACC_W-15){1'b0}}, lim_ff};
   assign lim18 = {3'd0, lim_ff};
   assign sl_ext = {3'd0, slew_ff};
   assign delta = {{2{v_ff[15]}}, v_ff} - {{2{last_out_ff[15]}}, last_out_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      dt_in = dt_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      raw_in = raw_ff;
      acc_in = acc_ff;
      v_in = v_ff;
      res_in = res_ff;
      integ_in = integ_ff;
      prev_int_in = prev_int_ff;
      last_err_in = last_err_ff;
      sm_in = sm_ff;
      last_out_in = last_out_ff;
      seeded_in = seeded_ff;
      v2 = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_corr_in = rsp_corr_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               err_in = req_error_in;
               dt_in = req_step_time;
               res_in = '0;
               if (req_type == 1'(REQ_CLEAR)) begin
                  integ_in = '0;
                  last_err_in = '0;
                  sm_in = '0;
                  last_out_in = '0;
                  seeded_in = 1'b0;
                  state_in = S_DONE;
               end else if (req_step_time == 32'd0) begin
                  state_in = S_DONE;
               end else begin
                  // first update after clear: seed, so the difference is zero
                  if (!seeded_ff) begin
                     sm_in = '0;
                     last_out_in = '0;
                     seeded_in = 1'b1;
                     neg_in = 1'b0;
                     quo_in = '0;
                  end else begin
                     neg_in = diff[32];
                     quo_in = {mag, 24'd0};
                  end
                  rem_in = '0;
                  cnt_in = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (!trial[33]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = shifted[31:0];
            end
            quo_in = {quo_ff[NUM_W-2:0], ~trial[33]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W - 1)) begin
               state_in = S_RAW;
            end
         end
         S_RAW: begin
            raw_in = neg_ff ? (48'sd0 - $signed(qmag)) : $signed(qmag);
            state_in = S_FAH;
         end
         S_FAH: state_in = S_FAHA;
         S_FAHA: begin
            // raw*65536 + alpha*(smoothed - raw)
            acc_in = (raw_ext <<< 16) + (prod_ext <<< 24);
            state_in = S_FAL;
         end
         S_FAL: state_in = S_FALA;
         S_FALA: begin
            acc_in = acc_ff + prod_ext;
            state_in = S_FAD;
         end
         S_FAD: begin
            sm_in = 48'((acc_ff + (acc_ff[ACC_W-1] ? 84'sh0FFFF : 84'sh0)) >>> 16);
            state_in = S_IM;
         end
         S_IM: state_in = S_IA;
         S_IA: begin
            prev_int_in = integ_ff;
            if (gain_i_ff != 32'sd0) begin
               if (isum > bnd_ext) begin
                  integ_in = 32'(bnd_ext);
               end else if (isum < -bnd_ext) begin
                  integ_in = 32'(-bnd_ext);
               end else begin
                  integ_in = isum[31:0];
               end
            end
            state_in = S_PM;
         end
         S_PM: state_in = S_PA;
         S_PA: begin
            acc_in = prod_ext;
            state_in = S_GM;
         end
         S_GM: state_in = S_GA;
         S_GA: begin
            acc_in = acc_ff + prod_ext;
            state_in = S_DHM;
         end
         S_DHM: state_in = S_DHA;
         S_DHA: begin
            acc_in = acc_ff + (prod_ext <<< 24);
            state_in = S_DLM;
         end
         S_DLM: state_in = S_DLA;
         S_DLA: begin
            acc_in = acc_ff + prod_ext;
            state_in = S_TR;
         end
         S_TR: begin
            // truncate Q.2F toward zero
            acc_in = rnd >>> TF;
            state_in = S_CL;
         end
         S_CL: begin
            if (acc_ff > lim_ext) begin
               v_in = {1'b0, lim_ff};
            end else if (acc_ff < -lim_ext) begin
               v_in = -$signed({1'b0, lim_ff});
            end else begin
               v_in = acc_ff[15:0];
            end
            state_in = S_SL;
         end
         S_SL: begin
            v2 = {{2{v_ff[15]}}, v_ff};
            if (slew_ff != 15'd0) begin
               if (delta > sl_ext) begin
                  v2 = {{2{last_out_ff[15]}}, last_out_ff} + sl_ext;
               end else if (delta < -sl_ext) begin
                  v2 = {{2{last_out_ff[15]}}, last_out_ff} - sl_ext;
               end
            end
            if (v2 > lim18) begin
               v2 = lim18;
            end else if (v2 < -lim18) begin
               v2 = -lim18;
            end
            res_in = v2[15:0];
            // anti-windup: pinned at a limit and error pushing further
            if (gain_i_ff != 32'sd0 &&
                ((v2 >= lim18 && err_ff > 32'sd0) ||
                 (v2 <= -lim18 && err_ff < 32'sd0))) begin
               integ_in = prev_int_ff;
            end
            last_err_in = err_ff;
            last_out_in = v2[15:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
      dt_ff <= dt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      raw_ff <= raw_in;
      acc_ff <= acc_in;
      v_ff <= v_in;
      res_ff <= res_in;
      prev_int_ff <= prev_int_in;
      rsp_corr_ff <= rsp_corr_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff <= '0;
         last_err_ff <= '0;
         sm_ff <= '0;
         last_out_ff <= '0;
         seeded_ff <= 1'b0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         alpha_ff <= '0;
         bound_ff <= '0;
         lim_ff <= CORR_LIMIT_RST;
         slew_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff <= integ_in;
         last_err_ff <= last_err_in;
         sm_ff <= sm_in;
         last_out_ff <= last_out_in;
         seeded_ff <= seeded_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN_P: gain_p_ff <= csr_wdata;
               CSR_GAIN_I: gain_i_ff <= csr_wdata;
               CSR_GAIN_D: gain_d_ff <= csr_wdata;
               CSR_ALPHA: alpha_ff <= csr_wdata[15:0];
               CSR_INT_BOUND: bound_ff <= csr_wdata[30:0];
               CSR_CORR_LIMIT: lim_ff <= csr_wdata[14:0];
               CSR_SLEW_LIMIT: slew_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_correction != 16'sh8000)
      else $error("response outside output range");
   a_seeded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SL |=> seeded_ff)
      else $error("update finished without seeding");
   a_last_out: assert property (@(posedge clock) disable iff (reset)
      last_out_ff != 16'sh8000)
      else $error("stored output outside range");
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

endmodule
